@@ src/acl_pkg.sv @@
// ----------------------------------------------------------------------------
// acl_pkg: shared types and constants
// item layouts, config codes and protocol numbers for the first-match acl
// ----------------------------------------------------------------------------
`default_nettype none

package acl_pkg;

    // fixed field widths
    localparam int IDX_W       = 4;
    localparam int PORT_W      = 16;
    localparam int ADDR_W      = 32;
    localparam int PROTO_W     = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // slots reachable through a 4-bit index
    localparam int INDEX_SLOTS       = 1 << IDX_W;
    localparam int DEFAULT_RULE_SLOTS = 16;

    // decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    localparam logic [ADDR_W-1:0] LOCAL_ADDR_RESET = 32'h7F00_0001;

    // operation codes
    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_NO_MATCH = 8'd1;

    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   entry_index;
        logic               entry_valid;
        logic               entry_allow;
        logic               entry_is_udp;
        logic [PORT_W-1:0]  entry_port;
        logic [ADDR_W-1:0]  entry_source;
        logic [PROTO_W-1:0] packet_protocol;
        logic [PORT_W-1:0]  packet_dest_port;
        logic [ADDR_W-1:0]  packet_source;
    } acl_in_t;

    typedef struct packed {
        logic             verdict_drop;
        logic             rule_hit;
        logic [IDX_W-1:0] hit_index;
        logic             local_bypass;
        logic             other_protocol;
    } acl_out_t;

    // configuration as seen by the front and back parts
    typedef struct packed {
        logic [ADDR_W-1:0] local_addr;
        logic              drop_no_match;
    } acl_cfg_t;

    // classified item held in the queue
    typedef struct packed {
        logic              is_write;
        logic [IDX_W-1:0]  entry_index;
        logic              entry_valid;
        logic              entry_allow;
        logic              entry_is_udp;
        logic [PORT_W-1:0] entry_port;
        logic [ADDR_W-1:0] entry_source;
        logic              local_hit;
        logic              other_proto;
        logic              pkt_udp;
        logic [PORT_W-1:0] dest_port;
        logic [ADDR_W-1:0] source;
    } acl_item_t;

endpackage

`default_nettype wire

@@ src/first_match_packet_acl_core.sv @@
// ----------------------------------------------------------------------------
// first_match_packet_acl_core: first-match packet filter top level
// rule writes and packet lookups share one input channel; packets get one
// verdict each, decided by local bypass, protocol, then the lowest-index rule
// ----------------------------------------------------------------------------
//
//  channel | signals                        | direction | moves
//  --------+--------------------------------+-----------+--------------------
//  input   | in_valid, in_stall, in_data    | in        | one write or packet item
//  output  | out_valid, out_stall, out_data | out       | one verdict item
//  config  | cfg_valid, cfg_ready,          | in        | one register write
//          | cfg_index, cfg_data            |           |
//
//  one item per cycle sustained while out_stall stays low; a packet's verdict
//  passes through the queue, the match stage and the output register, with the
//  match stage comparing every slot in parallel
//  rule writes take the same path and give no verdict
//  reset clears all rule valid bits at once; no clearing pass
//  in_stall rises only when the four-entry queue is full behind a stalled output
//
`default_nettype none

module first_match_packet_acl_core
    import acl_pkg::*;
#(
    parameter int RULE_SLOTS = DEFAULT_RULE_SLOTS
)
(
    input  wire                  clk,
    input  wire                  rst_n,

    // item input
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire acl_in_t         in_data,

    // verdict output
    output logic                 out_valid,
    input  wire                  out_stall,
    output acl_out_t             out_data,

    // register writes
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [ADDR_W-1:0] local_addr_reg;
    logic [ADDR_W-1:0] local_addr_next;
    logic              drop_no_match_reg;
    logic              drop_no_match_next;
    acl_cfg_t          cfg;

    // front to queue
    acl_item_t         front_item;
    logic              queue_full;
    logic              push;

    // queue to back
    acl_item_t         head_item;
    logic              queue_empty;
    logic              pop;

    // writes are taken any cycle; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_comb
    begin
        local_addr_next    = local_addr_reg;
        drop_no_match_next = drop_no_match_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDR:    local_addr_next    = cfg_data[ADDR_W-1:0];
                CFG_DROP_NO_MATCH: drop_no_match_next = cfg_data[0];
                default:           ; // unknown index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg    <= LOCAL_ADDR_RESET;
            drop_no_match_reg <= 1'b0;
        end
        else
        begin
            local_addr_reg    <= local_addr_next;
            drop_no_match_reg <= drop_no_match_next;
        end
    end

    assign cfg.local_addr    = local_addr_reg;
    assign cfg.drop_no_match = drop_no_match_reg;

    // input side stalls only on a full queue
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // classify: write vs packet, local bypass, non tcp/udp bypass
    acl_front u_front
    (
        .in_data (in_data),
        .cfg     (cfg),
        .item    (front_item)
    );

    // decoupling queue
    acl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (head_item),
        .empty     (queue_empty)
    );

    // rule table, lookup and verdict register
    acl_back #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (!queue_empty),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

@@ src/acl_front.sv @@
// ----------------------------------------------------------------------------
// acl_front: item decode and early classification
// splits rule writes from packets and resolves the local and protocol bypass
// ----------------------------------------------------------------------------
`default_nettype none

module acl_front
    import acl_pkg::*;
(
    input  wire acl_in_t  in_data,
    input  wire acl_cfg_t cfg,
    output acl_item_t     item
);

    logic is_tcp;
    logic is_udp;
    logic local_hit;

    assign is_tcp    = (in_data.packet_protocol == PROTO_TCP);
    assign is_udp    = (in_data.packet_protocol == PROTO_UDP);
    // local source wins over the protocol check
    assign local_hit = (in_data.packet_source == cfg.local_addr);

    always_comb
    begin
        item.is_write     = (in_data.func == FUNC_WRITE);
        item.entry_index  = in_data.entry_index;
        item.entry_valid  = in_data.entry_valid;
        item.entry_allow  = in_data.entry_allow;
        item.entry_is_udp = in_data.entry_is_udp;
        item.entry_port   = in_data.entry_port;
        item.entry_source = in_data.entry_source;
        item.local_hit    = local_hit;
        item.other_proto  = !local_hit && !is_tcp && !is_udp;
        item.pkt_udp      = is_udp;
        item.dest_port    = in_data.packet_dest_port;
        item.source       = in_data.packet_source;
    end

endmodule

`default_nettype wire

@@ src/acl_queue.sv @@
// ----------------------------------------------------------------------------
// acl_queue: small fifo between front and back
// lets the input side keep taking items while the back part is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module acl_queue
    import acl_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  wire acl_item_t push_item,
    output logic           full,
    input  wire            pop,
    output acl_item_t      pop_item,
    output logic           empty
);

    acl_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ src/acl_back.sv @@
// ----------------------------------------------------------------------------
// acl_back: rule table, parallel match and verdict
// applies rule writes in order and runs packets through a two-stage lookup
// ----------------------------------------------------------------------------
`default_nettype none

module acl_back
    import acl_pkg::*;
#(
    parameter int RULE_SLOTS = DEFAULT_RULE_SLOTS
)
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire acl_cfg_t  cfg,
    input  wire            head_valid,
    input  wire acl_item_t head_item,
    output logic           pop,
    output logic           out_valid,
    input  wire            out_stall,
    output acl_out_t       out_data
);

    // slots past the 4-bit index range can never be written
    localparam int USED_SLOTS = (RULE_SLOTS < INDEX_SLOTS) ? RULE_SLOTS : INDEX_SLOTS;

    // rule table: valid bits reset, payload written only
    logic [USED_SLOTS-1:0] valid_reg;
    logic [USED_SLOTS-1:0] allow_reg;
    logic [USED_SLOTS-1:0] udp_reg;
    logic [PORT_W-1:0]     port_reg [USED_SLOTS];
    logic [ADDR_W-1:0]     source_reg [USED_SLOTS];

    // lookup stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [USED_SLOTS-1:0] s1_match_reg;
    logic [USED_SLOTS-1:0] s1_allow_reg;
    logic                  s1_local_reg;
    logic                  s1_other_reg;

    // output stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    acl_out_t              out_data_reg;
    acl_out_t              out_data_next;

    logic                  out_free;
    logic                  s1_room;
    logic                  do_write;
    logic                  do_lookup;
    logic [USED_SLOTS-1:0] match_vec;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_room   = !s1_valid_reg || out_free;
    assign pop       = head_valid && s1_room;
    assign do_write  = pop && head_item.is_write;
    assign do_lookup = pop && !head_item.is_write;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // every slot compared at once
    always_comb
    begin
        for (int i = 0; i < USED_SLOTS; i++)
        begin
            match_vec[i] = valid_reg[i]
                && (udp_reg[i] == head_item.pkt_udp)
                && ((port_reg[i] == '0) || (port_reg[i] == head_item.dest_port))
                && ((source_reg[i] == '0) || (source_reg[i] == head_item.source))
                && !head_item.local_hit && !head_item.other_proto;
        end
    end

    // lowest index wins
    always_comb
    begin
        out_data_next                = '0;
        out_data_next.local_bypass   = s1_local_reg;
        out_data_next.other_protocol = s1_other_reg;
        out_data_next.verdict_drop   = !s1_local_reg && !s1_other_reg && cfg.drop_no_match;
        for (int i = USED_SLOTS - 1; i >= 0; i--)
        begin
            if (s1_match_reg[i])
            begin
                out_data_next.rule_hit     = 1'b1;
                out_data_next.hit_index    = IDX_W'(i);
                out_data_next.verdict_drop = !s1_allow_reg[i];
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_room ? do_lookup : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < USED_SLOTS; i++)
            begin
                if (do_write && (head_item.entry_index == IDX_W'(i)))
                begin
                    valid_reg[i] <= head_item.entry_valid;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < USED_SLOTS; i++)
        begin
            if (do_write && (head_item.entry_index == IDX_W'(i)))
            begin
                allow_reg[i]  <= head_item.entry_allow;
                udp_reg[i]    <= head_item.entry_is_udp;
                port_reg[i]   <= head_item.entry_port;
                source_reg[i] <= head_item.entry_source;
            end
        end
        if (do_lookup)
        begin
            s1_match_reg <= match_vec;
            s1_allow_reg <= allow_reg;
            s1_local_reg <= head_item.local_hit;
            s1_other_reg <= head_item.other_proto;
        end
        if (out_free && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the first-match packet acl core
// mixes rule writes and packet lookups on the input channel and predicts
// every verdict from a model of the rule table kept in a scoreboard; the
// register settings change between phases while the core is idle, and both
// channels idle and stall at random
// ----------------------------------------------------------------------------

module tb_top;
    import acl_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int IDLE_RARE       = 6;
    localparam int IDLE_HEAVY      = 70;
    localparam int IDLE_NONE       = 0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;   // no register here

    typedef struct packed {
        logic              valid;
        logic              allow;
        logic              is_udp;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] source;
    } acl_rule_t;

    // ------------------------------------------------------------------------
    // scoreboard: rule table and register model, queue of expected verdicts
    // ------------------------------------------------------------------------
    class verdict_checker;
        acl_rule_t         rules [INDEX_SLOTS];
        logic [ADDR_W-1:0] local_addr;
        logic              drop_no_match;
        acl_out_t          pending_verdicts [$];
        int unsigned       failures;
        int unsigned       packets, writes, verdicts;
        int unsigned       rule_hits, bypasses, other_protos, defaults;

        function new();
            foreach (rules[i])
                rules[i] = '0;
            local_addr    = LOCAL_ADDR_RESET;
            drop_no_match = 1'b0;
            failures = 0;
            packets = 0;
            writes = 0;
            verdicts = 0;
            rule_hits = 0;
            bypasses = 0;
            other_protos = 0;
            defaults = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LOCAL_ADDR:    local_addr    = data[ADDR_W-1:0];
                CFG_DROP_NO_MATCH: drop_no_match = data[0];
                default: ;
            endcase
        endfunction

        // local bypass first, then protocol, then the lowest matching slot
        function acl_out_t predict_verdict(acl_in_t it);
            acl_out_t v;
            logic     pkt_udp;
            v = '0;
            if (it.packet_source == local_addr) begin
                v.local_bypass = 1'b1;
            end
            else if (it.packet_protocol != PROTO_TCP && it.packet_protocol != PROTO_UDP) begin
                v.other_protocol = 1'b1;
            end
            else begin
                pkt_udp        = (it.packet_protocol == PROTO_UDP);
                v.verdict_drop = drop_no_match;
                for (int i = 0; i < DEFAULT_RULE_SLOTS; i++) begin
                    if (!v.rule_hit && rules[i].valid && rules[i].is_udp == pkt_udp
                        && (rules[i].port == '0 || rules[i].port == it.packet_dest_port)
                        && (rules[i].source == '0 || rules[i].source == it.packet_source))
                    begin
                        v.rule_hit     = 1'b1;
                        v.hit_index    = IDX_W'(i);
                        v.verdict_drop = !rules[i].allow;
                    end
                end
            end
            return v;
        endfunction

        // called at the edge where the core takes an input item
        function void note_item(acl_in_t it);
            acl_out_t v;
            if (it.func == FUNC_WRITE) begin
                writes++;
                if (it.entry_index < DEFAULT_RULE_SLOTS)
                    rules[it.entry_index] = '{it.entry_valid, it.entry_allow,
                                              it.entry_is_udp, it.entry_port,
                                              it.entry_source};
            end
            else begin
                packets++;
                v = predict_verdict(it);
                if (v.rule_hit)
                    rule_hits++;
                else if (v.local_bypass)
                    bypasses++;
                else if (v.other_protocol)
                    other_protos++;
                else
                    defaults++;
                pending_verdicts.push_back(v);
            end
        endfunction

        function void compare_field(string name, logic [IDX_W-1:0] want,
                                    logic [IDX_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_verdict(acl_out_t got);
            acl_out_t want;
            if (pending_verdicts.size() == 0) begin
                $error("verdict item with nothing pending: %p", got);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            verdicts++;
            compare_field("verdict_drop",   want.verdict_drop,   got.verdict_drop);
            compare_field("rule_hit",       want.rule_hit,       got.rule_hit);
            compare_field("hit_index",      want.hit_index,      got.hit_index);
            compare_field("local_bypass",   want.local_bypass,   got.local_bypass);
            compare_field("other_protocol", want.other_protocol, got.other_protocol);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // core hookup
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    acl_in_t               in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    acl_out_t              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    verdict_checker board = new();

    int unsigned send_idle_pct  = IDLE_RARE;
    int unsigned recv_stall_pct = IDLE_HEAVY;
    int unsigned quiet_cycles   = 0;
    int unsigned config_rounds  = 0;

    first_match_packet_acl_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // receiver: check each taken verdict item against the oldest prediction,
    // then pick the stall for the next cycle; reads here see pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_verdict(out_data);
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: counts cycles in which no channel moves anything
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $error("no handshake for %0d cycles, %0d verdicts outstanding",
               WATCHDOG_LIMIT, board.pending_verdicts.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // item builders; fields the operation ignores carry random bits
    // ------------------------------------------------------------------------
    function automatic acl_in_t random_item();
        bit [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(acl_in_t)-1:0];
    endfunction

    function automatic acl_in_t rule_write(logic [IDX_W-1:0] idx, logic valid, logic allow,
                                           logic udp, logic [PORT_W-1:0] port,
                                           logic [ADDR_W-1:0] src);
        acl_in_t it;
        it              = random_item();
        it.func         = FUNC_WRITE;
        it.entry_index  = idx;
        it.entry_valid  = valid;
        it.entry_allow  = allow;
        it.entry_is_udp = udp;
        it.entry_port   = port;
        it.entry_source = src;
        return it;
    endfunction

    function automatic acl_in_t packet_lookup(logic [PROTO_W-1:0] proto,
                                              logic [PORT_W-1:0] port,
                                              logic [ADDR_W-1:0] src);
        acl_in_t it;
        it                  = random_item();
        it.func             = FUNC_CLASSIFY;
        it.packet_protocol  = proto;
        it.packet_dest_port = port;
        it.packet_source    = src;
        return it;
    endfunction

    // small pools so that rules and packets actually meet
    function automatic logic [PORT_W-1:0] pooled_port();
        case ($urandom_range(4))
            0:       return 16'd80;
            1:       return 16'd443;
            2:       return 16'd53;
            3:       return 16'hFFFF;
            default: return 16'd1;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pooled_source();
        case ($urandom_range(3))
            0:       return 32'h0A00_0001;
            1:       return 32'hC0A8_0101;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic acl_in_t make_rule_write();
        int unsigned       r;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] src;
        r    = $urandom_range(9);
        port = (r < 3) ? '0 : (r < 8) ? pooled_port() : PORT_W'($urandom);
        r    = $urandom_range(9);
        src  = (r < 3) ? '0 : (r < 8) ? pooled_source() : $urandom;
        // mostly live rules, some removals
        return rule_write(IDX_W'($urandom), $urandom_range(99) < 85, 1'($urandom_range(1)),
                          1'($urandom_range(1)), port, src);
    endfunction

    function automatic acl_in_t make_packet();
        int unsigned        r;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  port;
        logic [ADDR_W-1:0]  src;
        r     = $urandom_range(19);
        proto = (r < 9) ? PROTO_TCP : (r < 17) ? PROTO_UDP : PROTO_W'($urandom);
        port  = ($urandom_range(9) < 7) ? pooled_port() : PORT_W'($urandom);
        r     = $urandom_range(9);
        src   = (r < 6) ? pooled_source() : (r < 7) ? board.local_addr : $urandom;
        return packet_lookup(proto, port, src);
    endfunction

    // ------------------------------------------------------------------------
    // drivers; every task starts and ends in the time step of a rising edge
    // ------------------------------------------------------------------------
    task automatic drive_item(input acl_in_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        board.note_item(it);
    endtask

    // hold the input back until every predicted verdict has come out
    task automatic wait_for_verdicts();
        if (board.pending_verdicts.size() != 0) begin
            in_valid <= 1'b0;
            while (board.pending_verdicts.size() != 0)
                @(posedge clk);
        end
    endtask

    // idle point: drained, and rule writes behind the last verdict are done
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input logic [ADDR_W-1:0] local_word,
                                     input logic drop_bit, input bit poke_unused);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] dat [3];
        int                    n;
        idx[0] = CFG_LOCAL_ADDR;
        dat[0] = local_word;
        idx[1] = CFG_DROP_NO_MATCH;
        dat[1] = $urandom;          // only bit 0 counts
        dat[1][0] = drop_bit;
        idx[2] = CFG_UNUSED;
        dat[2] = $urandom;
        n = poke_unused ? 3 : 2;
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= dat[k];
            do @(posedge clk); while (!cfg_ready);
            board.set_register(idx[k], dat[k]);
        end
        cfg_valid <= 1'b0;
        config_rounds++;
    endtask

    // mostly packets, a steady trickle of rule changes, one drain midway
    task automatic run_random_phase(input int n_items);
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2)
                wait_for_verdicts();
            if ($urandom_range(99) < 30)
                drive_item(make_rule_write());
            else
                drive_item(make_packet());
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset settings: sender idles rarely, receiver often
        send_idle_pct  = IDLE_RARE;
        recv_stall_pct = IDLE_HEAVY;
        // empty table gives the default verdict
        drive_item(packet_lookup(PROTO_TCP, 16'd80, 32'h0A00_0001));
        // local source wins even over a foreign protocol
        drive_item(packet_lookup(8'd1, 16'd0, LOCAL_ADDR_RESET));
        // protocol extremes that are neither tcp nor udp
        drive_item(packet_lookup(8'd0, 16'hFFFF, 32'h0A00_0001));
        drive_item(packet_lookup(8'hFF, 16'd0, 32'hFFFF_FFFF));
        // wildcard tcp block rule in the last slot
        drive_item(rule_write(4'd15, 1'b1, 1'b0, 1'b0, 16'd0, 32'd0));
        drive_item(packet_lookup(PROTO_TCP, 16'd80, 32'h0A00_0001));
        drive_item(packet_lookup(PROTO_UDP, 16'd80, 32'h0A00_0001));
        // exact allow rule in the first slot, all-ones port and source
        drive_item(rule_write(4'd0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
        drive_item(packet_lookup(PROTO_TCP, 16'hFFFF, 32'hFFFF_FFFF));
        drive_item(packet_lookup(PROTO_TCP, 16'hFFFF, 32'h0A00_0001));
        // udp port rule, then a source-only udp rule further down
        drive_item(rule_write(4'd3, 1'b1, 1'b0, 1'b1, 16'd53, 32'd0));
        drive_item(packet_lookup(PROTO_UDP, 16'd53, 32'hC0A8_0101));
        drive_item(packet_lookup(PROTO_UDP, 16'd54, 32'hC0A8_0101));
        drive_item(rule_write(4'd7, 1'b1, 1'b1, 1'b1, 16'd0, 32'hC0A8_0101));
        drive_item(packet_lookup(PROTO_UDP, 16'd54, 32'hC0A8_0101));
        drive_item(packet_lookup(PROTO_UDP, 16'd53, 32'hC0A8_0101));
        // local source bypasses a matching block rule
        drive_item(packet_lookup(PROTO_TCP, 16'd80, LOCAL_ADDR_RESET));
        // removing the wildcard rule
        drive_item(rule_write(4'd15, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0));
        drive_item(packet_lookup(PROTO_TCP, 16'd80, 32'h0A00_0001));
        // zero source and port on a packet
        drive_item(packet_lookup(PROTO_TCP, 16'd0, 32'd0));
        drive_item(packet_lookup(8'd0, 16'd0, 32'd0));
        wait_for_verdicts();

        run_random_phase(140);

        // all-ones local address, drop on no match; sender idles often
        settle();
        program_registers(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_idle_pct  = IDLE_HEAVY;
        recv_stall_pct = IDLE_RARE;
        run_random_phase(140);

        // zero local address, accept on no match, a write to a missing
        // register on the side; no idling from here on
        settle();
        program_registers(32'd0, 1'b0, 1'b1);
        send_idle_pct  = IDLE_NONE;
        recv_stall_pct = IDLE_NONE;
        run_random_phase(80);

        settle();
        program_registers($urandom, 1'b1, 1'b0);
        run_random_phase(80);

        settle();
        if (board.pending_verdicts.size() != 0) begin
            $error("%0d verdicts never came out", board.pending_verdicts.size());
            board.failures += board.pending_verdicts.size();
        end
        $display("covered %0d packet lookups and %0d rule writes over %0d register settings",
                 board.packets, board.writes, config_rounds + 1);
        $display("verdicts checked %0d: rule %0d, local %0d, other protocol %0d, default %0d",
                 board.verdicts, board.rule_hits, board.bypasses, board.other_protos,
                 board.defaults);
        if (board.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
